FILE: sv/hpq_pkg.sv
package hpq_pkg;

    // Field widths of the request and response channels.
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 9;
    localparam int COUNT_W = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 2'd0,
        FN_EXTRACT = 2'd1,
        FN_PEEK    = 2'd2,
        FN_ADJUST  = 2'd3
    } hpq_func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_POS = 2'd3
    } hpq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DOWN,
        ST_UP,
        ST_FINISH
    } hpq_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] amount;
    } hpq_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
    } hpq_resp_t;

endpackage

FILE: sv/hpq_if.sv
interface hpq_req_if
    import hpq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] amount;

    modport source (output valid, func, value, position, amount, input ready);
    modport sink (input valid, func, value, position, amount, output ready);
endinterface

interface hpq_rsp_if
    import hpq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, result_value, status, count, input ready);
    modport sink (input valid, result_value, status, count, output ready);
endinterface

FILE: sv/max_heap_priority_queue_unit.sv
// Binary max-heap priority queue. Each request inserts a key, extracts or
// peeks the largest key, or adds a signed amount to the key at a 1-based
// position (saturating at the key range), and gets exactly one response
// with the returned key, a status and the entry count afterwards. Requests
// are handled one at a time. The heap lives in a two-read, one-write
// synchronous RAM, and the sift loop walks one tree level per clock: the
// registered read of the next level is issued in the same cycle as the
// compare and the write of the current one. The finished response is
// handed to the output register and offered on the response channel in
// the next cycle; the next request is taken in the cycle after the
// response is handed to the output register. A response waits in the
// output register while the next request is already being worked on. The
// store needs no clearing after reset, since only keys in slots up to the
// count are ever used.
module max_heap_priority_queue_unit
    import hpq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    hpq_req_if.sink   req,
    hpq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);

    hpq_req_t              core_req;
    hpq_resp_t             core_resp;
    hpq_resp_t             out_reg;
    logic                  out_valid_reg;
    logic                  core_done;
    logic                  out_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [DATA_WIDTH-1:0] mem_rdata_a;
    logic [DATA_WIDTH-1:0] mem_rdata_b;

    assign core_req.func     = req.func;
    assign core_req.value    = req.value;
    assign core_req.position = req.position;
    assign core_req.amount   = req.amount;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || rsp.ready;

    hpq_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .IW         (IW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req         (core_req),
        .req_ready   (req.ready),
        .done        (core_done),
        .resp        (core_resp),
        .out_free    (out_free),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    hpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Output register: takes the finished response and holds it until the
    // consumer accepts it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done && out_free)
        begin
            out_reg <= core_resp;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_reg.result_value;
    assign rsp.status       = out_reg.status;
    assign rsp.count        = out_reg.count;

endmodule

FILE: sv/hpq_mem.sv
module hpq_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/hpq_core.sv
module hpq_core
    import hpq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(CAPACITY),
    parameter int IW         = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  hpq_req_t              req,
    output logic                  req_ready,
    output logic                  done,
    output hpq_resp_t             resp,
    input  logic                  out_free,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic [AW-1:0]         mem_raddr_a,
    output logic [AW-1:0]         mem_raddr_b,
    input  logic [DATA_WIDTH-1:0] mem_rdata_a,
    input  logic [DATA_WIDTH-1:0] mem_rdata_b
);

    localparam int SW = IW + 2;
    localparam int XW = ((DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W) + 2;
    localparam int PW = IW + POS_W;
    localparam int CW = IW + COUNT_W;
    localparam logic [IW-1:0] CAP_C = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_I = IW'(1);
    localparam logic signed [XW-1:0] ONE_X = XW'(1);
    localparam logic signed [XW-1:0] KMAX_X = (ONE_X <<< (DATA_WIDTH - 1)) - ONE_X;
    localparam logic signed [XW-1:0] KMIN_X = -KMAX_X - ONE_X;

    typedef logic signed [DATA_WIDTH-1:0] key_t;

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
        logic [SW-1:0] t;
        t = slot - SW'(1);
        return t[AW-1:0];
    endfunction

    function automatic key_t saturate(input logic signed [XW-1:0] s);
        logic signed [XW-1:0] c;
        c = s;
        if (s > KMAX_X)
        begin
            c = KMAX_X;
        end
        else if (s < KMIN_X)
        begin
            c = KMIN_X;
        end
        return c[DATA_WIDTH-1:0];
    endfunction

    hpq_state_t                state_reg, state_next;
    hpq_func_t                 op_reg, op_next;
    logic [IW-1:0]             cnt_reg, cnt_next;
    logic [IW-1:0]             idx_reg, idx_next;
    key_t                      cur_reg, cur_next;
    logic signed [VALUE_W-1:0] amt_reg, amt_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    hpq_status_t               status_reg, status_next;
    logic                      moved_reg, moved_next;

    hpq_func_t        req_func;
    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    cnt_x;
    logic [SW-1:0]    left_s, right_s, cnt_s, idx_s;
    logic             left_ok, right_ok, take_left, take_right;
    key_t             rd_a, rd_b, big_v;
    logic [IW-1:0]    child;
    logic signed [XW-1:0] rd_a_x;
    logic [CW-1:0]    cnt_w;

    assign req_func = hpq_func_t'(req.func);
    assign pos_x    = PW'(req.position);
    assign cnt_x    = PW'(cnt_reg);
    assign rd_a     = key_t'(mem_rdata_a);
    assign rd_b     = key_t'(mem_rdata_b);
    assign rd_a_x   = XW'(rd_a);
    assign idx_s    = SW'(idx_reg);
    assign cnt_s    = SW'(cnt_reg);
    assign left_s   = SW'({idx_reg, 1'b0});
    assign right_s  = SW'({idx_reg, 1'b1});

    // Shared compare unit of the sift-down step: larger of current key and children.
    assign left_ok    = (left_s <= cnt_s);
    assign right_ok   = (right_s <= cnt_s);
    assign take_left  = left_ok && (cur_reg < rd_a);
    assign big_v      = take_left ? rd_a : cur_reg;
    assign take_right = right_ok && (big_v < rd_b);
    assign child      = take_right ? right_s[IW-1:0] : left_s[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        amt_reg    <= amt_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        moved_reg  <= moved_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        amt_next    = amt_reg;
        res_next    = res_reg;
        status_next = status_reg;
        moved_next  = moved_reg;
        req_ready   = 1'b0;
        done        = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = slot_addr(idx_s);
        mem_wdata   = cur_reg;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next     = req_func;
                    res_next    = '0;
                    status_next = STAT_OK;
                    amt_next    = req.amount;
                    case (req_func)
                        FN_INSERT:
                        begin
                            if (cnt_reg == CAP_C)
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                cnt_next    = cnt_reg + ONE_I;
                                idx_next    = cnt_reg + ONE_I;
                                cur_next    = saturate(XW'(req.value));
                                mem_raddr_a = slot_addr(SW'((cnt_reg + ONE_I) >> 1));
                                state_next  = ST_UP;
                            end
                        end
                        FN_EXTRACT, FN_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                mem_raddr_a = slot_addr(SW'(1));
                                mem_raddr_b = slot_addr(cnt_s);
                                state_next  = ST_LOAD;
                            end
                        end
                        FN_ADJUST:
                        begin
                            if ((pos_x == '0) || (pos_x > cnt_x))
                            begin
                                status_next = STAT_BAD_POS;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                idx_next    = pos_x[IW-1:0];
                                mem_raddr_a = slot_addr(SW'(pos_x[IW-1:0]));
                                state_next  = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                moved_next = 1'b0;
                case (op_reg)
                    FN_PEEK:
                    begin
                        res_next   = rd_a_x[VALUE_W-1:0];
                        state_next = ST_FINISH;
                    end
                    FN_EXTRACT:
                    begin
                        res_next = rd_a_x[VALUE_W-1:0];
                        cur_next = rd_b;
                        cnt_next = cnt_reg - ONE_I;
                        idx_next = ONE_I;
                        mem_raddr_a = slot_addr(SW'(2));
                        mem_raddr_b = slot_addr(SW'(3));
                        state_next  = (cnt_reg == ONE_I) ? ST_FINISH : ST_DOWN;
                    end
                    FN_ADJUST:
                    begin
                        cur_next    = saturate(rd_a_x + XW'(amt_reg));
                        mem_raddr_a = slot_addr(left_s);
                        mem_raddr_b = slot_addr(right_s);
                        state_next  = ST_DOWN;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_DOWN:
            begin
                if (take_left || take_right)
                begin
                    // Child moves up into the hole; the hole moves down.
                    mem_we      = 1'b1;
                    mem_wdata   = take_right ? rd_b : rd_a;
                    idx_next    = child;
                    moved_next  = 1'b1;
                    mem_raddr_a = slot_addr(SW'({child, 1'b0}));
                    mem_raddr_b = slot_addr(SW'({child, 1'b1}));
                end
                else if ((op_reg == FN_ADJUST) && !moved_reg)
                begin
                    // Key did not sink, so it may have to rise instead.
                    mem_raddr_a = slot_addr(SW'(idx_reg >> 1));
                    state_next  = ST_UP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_UP:
            begin
                mem_we = 1'b1;
                if ((idx_reg == ONE_I) || !(rd_a < cur_reg))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_wdata   = rd_a;
                    idx_next    = idx_reg >> 1;
                    mem_raddr_a = slot_addr(SW'(idx_reg >> 2));
                end
            end

            ST_FINISH:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_w               = CW'(cnt_reg);
    assign resp.result_value   = res_reg;
    assign resp.status         = status_reg;
    assign resp.count          = cnt_w[COUNT_W-1:0];

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH) |-> !mem_we)
        else $error("store written outside a sift");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && req_valid && req_func == FN_INSERT && cnt_reg != CAP_C)
        |=> (cnt_reg == $past(cnt_reg) + ONE_I))
        else $error("insert did not grow the heap");

    a_down_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DOWN || state_reg == ST_UP)
        |-> (idx_reg != '0 && idx_reg <= cnt_reg))
        else $error("sift index outside the heap");

endmodule

FILE: sim/tb_top.sv
module tb_top
    import hpq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // The heap is checked at its default size, so that the full case can be reached.
    localparam int HEAP_SLOTS = 256;
    localparam longint KEY_MAX = 64'sd2147483647;
    localparam longint KEY_MIN = -64'sd2147483648;

    // A small scoreboard that keeps its own copy of the heap. Each accepted request
    // is applied to that copy at once, and the response it must produce is queued.
    // Responses leave the block in request order, so each one is checked against
    // the oldest queued response.
    class priority_queue_tracker;
        logic signed [VALUE_W-1:0] keys [1:HEAP_SLOTS];
        int unsigned               held;
        hpq_resp_t                 expected_responses [$];
        int                        mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void swap_keys(int unsigned a, int unsigned b);
            logic signed [VALUE_W-1:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        // Moves the key at slot i down while a child is strictly larger. When both
        // children are larger and equal, the left one wins. Returns the final slot.
        function int unsigned sink_key(int unsigned i);
            int unsigned l;
            int unsigned big;
            forever
            begin
                l = 2 * i;
                big = i;
                if (l > held)
                    break;
                if (keys[big] < keys[l])
                    big = l;
                if (l + 1 <= held && keys[big] < keys[l + 1])
                    big = l + 1;
                if (big == i)
                    break;
                swap_keys(i, big);
                i = big;
            end
            return i;
        endfunction

        function void raise_key(int unsigned i);
            while (i > 1 && keys[i / 2] < keys[i])
            begin
                swap_keys(i, i / 2);
                i = i / 2;
            end
        endfunction

        function void note_request(hpq_req_t r);
            hpq_resp_t e;
            longint    sum;
            e = '0;
            case (hpq_func_t'(r.func))
                FN_INSERT:
                begin
                    if (held >= HEAP_SLOTS)
                        e.status = STAT_FULL;
                    else
                    begin
                        held++;
                        keys[held] = r.value;
                        raise_key(held);
                    end
                end
                FN_EXTRACT, FN_PEEK:
                begin
                    if (held == 0)
                        e.status = STAT_EMPTY;
                    else
                    begin
                        e.result_value = keys[1];
                        if (hpq_func_t'(r.func) == FN_EXTRACT)
                        begin
                            keys[1] = keys[held];
                            held--;
                            if (held > 0)
                                void'(sink_key(1));
                        end
                    end
                end
                default:
                begin
                    if (r.position == 0 || r.position > held)
                        e.status = STAT_BAD_POS;
                    else
                    begin
                        sum = longint'(keys[r.position]) + longint'(r.amount);
                        if (sum > KEY_MAX)
                            sum = KEY_MAX;
                        else if (sum < KEY_MIN)
                            sum = KEY_MIN;
                        keys[r.position] = sum[VALUE_W-1:0];
                        raise_key(sink_key(r.position));
                    end
                end
            endcase
            e.count = held[COUNT_W-1:0];
            expected_responses = {expected_responses, e};
        endfunction

        function void check_response(hpq_resp_t got);
            hpq_resp_t e;
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request outstanding: %s %0d %0d %0d",
                             "value/status/count", got.result_value, got.status,
                             got.count);
                return;
            end
            e = expected_responses.pop_front();
            if (got.result_value !== e.result_value || got.status !== e.status
                || got.count !== e.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch (exp/got): value %0d/%0d %s",
                             e.result_value, got.result_value,
                             $sformatf("status %0d/%0d count %0d/%0d",
                                       e.status, got.status, e.count, got.count));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    hpq_req_if rq ();
    hpq_rsp_if rs ();

    max_heap_priority_queue_unit #(
        .CAPACITY   (HEAP_SLOTS),
        .DATA_WIDTH (VALUE_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rq.sink),
        .rsp   (rs.source)
    );

    always #6 clk = ~clk;

    priority_queue_tracker tracker;

    // Number of further requests the sender issues back to back before it takes
    // another gap.
    int burst_left = 0;

    // The receiver switches between stall behaviors at random intervals: always
    // ready, a rotating random mask, mostly stalled, and mostly ready. The first
    // mode is the always-ready one, so stretches without stalls do occur.
    logic [15:0] stall_mask;
    int          rx_left = 0;
    int          rx_mode = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_left <= $urandom_range(16, 96);
            rx_mode <= $urandom_range(0, 3);
            stall_mask <= 16'($urandom);
        end
        else
        begin
            rx_left <= rx_left - 1;
            stall_mask <= {stall_mask[14:0], stall_mask[15]};
        end
        case (rx_mode)
            0:       rs.ready <= 1'b1;
            1:       rs.ready <= stall_mask[0];
            2:       rs.ready <= ($urandom_range(0, 3) == 0);
            default: rs.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Every accepted response is checked at the edge where it is taken. The values
    // read here are the ones that held just before the edge.
    always @(posedge clk)
    begin
        hpq_resp_t got;
        if (rst_n === 1'b1 && rs.valid === 1'b1 && rs.ready === 1'b1)
        begin
            got.result_value = rs.result_value;
            got.status = rs.status;
            got.count = rs.count;
            tracker.check_response(got);
        end
    end

    // Drives one request and waits for the edge at which it is accepted. Valid
    // stays high into the next request unless the burst is over, in which case
    // the sender may lower it for a random gap.
    task automatic issue(input hpq_func_t fn, input logic signed [VALUE_W-1:0] key,
                         input logic [POS_W-1:0] slot, input logic signed [VALUE_W-1:0] delta);
        hpq_req_t r;
        int       gap;
        r.func = fn;
        r.value = key;
        r.position = slot;
        r.amount = delta;
        rq.valid <= 1'b1;
        rq.func <= fn;
        rq.value <= key;
        rq.position <= slot;
        rq.amount <= delta;
        @(posedge clk);
        while (rq.ready !== 1'b1)
            @(posedge clk);
        tracker.note_request(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                rq.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Keys lean toward a small range so that equal keys and equal siblings are
    // common, with the extremes mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 7) - 4;
            4:          return KEY_MAX[VALUE_W-1:0];
            5:          return KEY_MIN[VALUE_W-1:0];
            default:    return $urandom;
        endcase
    endfunction

    // Amounts include zero, both extremes (which saturate most keys) and small
    // steps in both directions.
    function automatic logic signed [VALUE_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return KEY_MAX[VALUE_W-1:0];
            2:          return KEY_MIN[VALUE_W-1:0];
            3, 4, 5:    return $urandom_range(0, 32) - 16;
            default:    return $urandom;
        endcase
    endfunction

    // Most positions are valid; the rest are zero or above the current count.
    function automatic logic [POS_W-1:0] pick_position();
        if (tracker.held > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, tracker.held));
        if (tracker.held < HEAP_SLOTS && $urandom_range(0, 1) == 1)
            return POS_W'($urandom_range(tracker.held + 1, HEAP_SLOTS));
        return '0;
    endfunction

    // One random request. The shares are percentages; adjust takes what is left.
    // Fields that the chosen kind ignores are filled with random bits.
    task automatic random_request(input int insert_pct, input int extract_pct,
                                  input int peek_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            issue(FN_INSERT, pick_key(), POS_W'($urandom), $urandom);
        else if (pick < insert_pct + extract_pct)
            issue(FN_EXTRACT, $urandom, POS_W'($urandom), $urandom);
        else if (pick < insert_pct + extract_pct + peek_pct)
            issue(FN_PEEK, $urandom, POS_W'($urandom), $urandom);
        else
            issue(FN_ADJUST, $urandom, pick_position(), pick_amount());
    endtask

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        rq.valid <= 1'b0;
        rq.func <= FN_INSERT;
        rq.value <= '0;
        rq.position <= '0;
        rq.amount <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. On an empty heap every request that reads the heap must
        // fail with the empty or bad-position status.
        issue(FN_EXTRACT, $urandom, POS_W'($urandom), $urandom);
        issue(FN_PEEK, $urandom, POS_W'($urandom), $urandom);
        issue(FN_ADJUST, $urandom, 9'd1, 32'sd5);

        // Both key extremes, a pair of equal keys and a negative key.
        issue(FN_INSERT, KEY_MAX[VALUE_W-1:0], POS_W'($urandom), $urandom);
        issue(FN_INSERT, KEY_MIN[VALUE_W-1:0], POS_W'($urandom), $urandom);
        issue(FN_INSERT, 32'sd0, POS_W'($urandom), $urandom);
        issue(FN_INSERT, 32'sd0, POS_W'($urandom), $urandom);
        issue(FN_INSERT, -32'sd1, POS_W'($urandom), $urandom);
        issue(FN_PEEK, $urandom, POS_W'($urandom), $urandom);

        // Positions of zero, one past the count, and the capacity of the heap
        // are all rejected.
        issue(FN_ADJUST, $urandom, 9'd0, 32'sd1);
        issue(FN_ADJUST, $urandom, 9'd6, 32'sd1);
        issue(FN_ADJUST, $urandom, 9'd256, 32'sd1);

        // Saturation at both ends, a zero amount and a small step upward.
        issue(FN_ADJUST, $urandom, 9'd1, KEY_MAX[VALUE_W-1:0]);
        issue(FN_ADJUST, $urandom, 9'd5, KEY_MIN[VALUE_W-1:0]);
        issue(FN_ADJUST, $urandom, 9'd2, 32'sd0);
        issue(FN_ADJUST, $urandom, 9'd3, 32'sd7);

        // Drain the heap and extract once more from the empty heap.
        repeat (6) issue(FN_EXTRACT, $urandom, POS_W'($urandom), $urandom);

        // Random part. First the heap is filled to capacity with mostly inserts,
        // then it is worked on near full so that some inserts are refused, and last
        // it is drained with mostly extracts.
        while (tracker.held < HEAP_SLOTS)
            random_request(88, 4, 3);
        repeat (30) random_request(50, 25, 10);
        repeat (120) random_request(10, 60, 10);

        rq.valid <= 1'b0;
        while (tracker.expected_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Far longer than the slowest correct run: about 460 requests, each with the
    // deepest sift, the longest sender gap and the longest receiver stall.
    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
